[rtl/kw_pkg.sv]
// ----------------------------------------------------------------------------
// kw_pkg
// Types and constants shared by the K-weighting filter modules.
// ----------------------------------------------------------------------------
package kw_pkg;

  localparam int CIDX_W = 3;
  localparam int SAMP_W = 24;
  localparam int OUT_W  = 30;
  localparam int REG_W  = 32;
  localparam int COEF_W = 37;
  localparam int HIST_W = 64;
  localparam int ACC_W  = 104;
  localparam int PP_W   = COEF_W + 33;
  localparam int ADDR_W = 5;
  localparam int NREGS  = 7;

  typedef enum logic [2:0] {
    REG_SHELF_NUM0,
    REG_SHELF_NUM1,
    REG_SHELF_NUM2,
    REG_SHELF_DEN1,
    REG_SHELF_DEN2,
    REG_HIGHPASS_DEN1,
    REG_HIGHPASS_DEN2
  } kw_reg_t;

  localparam logic signed [REG_W-1:0] RST_SHELF_NUM0    = 32'sd412081942;
  localparam logic signed [REG_W-1:0] RST_SHELF_NUM1    = -32'sd722546690;
  localparam logic signed [REG_W-1:0] RST_SHELF_NUM2    = 32'sd321691121;
  localparam logic signed [REG_W-1:0] RST_SHELF_DEN1    = -32'sd453832899;
  localparam logic signed [REG_W-1:0] RST_SHELF_DEN2    = 32'sd196623811;
  localparam logic signed [REG_W-1:0] RST_HIGHPASS_DEN1 = -32'sd534199296;
  localparam logic signed [REG_W-1:0] RST_HIGHPASS_DEN2 = 32'sd265770496;

  typedef logic signed [COEF_W-1:0] kw_cw_t;

  typedef struct packed {
    kw_cw_t b0;
    kw_cw_t b1;
    kw_cw_t b2;
    kw_cw_t b3;
    kw_cw_t b4;
    kw_cw_t a1;
    kw_cw_t a2;
    kw_cw_t a3;
    kw_cw_t a4;
  } kw_coef_t;

  typedef struct packed {
    logic [CIDX_W-1:0]        chan;
    logic signed [SAMP_W-1:0] sample;
    logic                     in_range;
  } kw_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_MAC_A,
    ST_DRAIN_A,
    ST_RND_V,
    ST_MAC_B,
    ST_DRAIN_B,
    ST_RND_Y,
    ST_DONE
  } kw_state_t;

  localparam logic [3:0] LAST_A = 4'd7;
  localparam logic [3:0] LAST_B = 4'd9;

endpackage

[rtl/kw_if.sv]
// ----------------------------------------------------------------------------
// kw_in_if / kw_out_if
// Valid/ready sample channels of the K-weighting filter.
// ----------------------------------------------------------------------------
interface kw_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        chan_index;
  logic signed [23:0] sample_in;

  modport source (output valid, output chan_index, output sample_in, input ready);
  modport sink (input valid, input chan_index, input sample_in, output ready);
endinterface

interface kw_out_if;
  logic              valid;
  logic              ready;
  logic [2:0]        chan_out;
  logic signed [29:0] weighted_out;

  modport source (output valid, output chan_out, output weighted_out, input ready);
  modport sink (input valid, input chan_out, input weighted_out, output ready);
endinterface

[rtl/kw_coef.sv]
// ----------------------------------------------------------------------------
// kw_coef
// Coefficient registers and the sequencer that convolves the two sections
// into the combined fourth-order coefficient set.
// ----------------------------------------------------------------------------
module kw_coef (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [kw_pkg::ADDR_W-1:0]  paddr,
  input  logic [kw_pkg::REG_W-1:0]   pwdata,
  output logic [kw_pkg::REG_W-1:0]   prdata,
  output kw_pkg::kw_coef_t           coef,
  output logic                       busy
);
  import kw_pkg::*;

  logic signed [REG_W-1:0]  regs_r [NREGS];
  logic signed [2*REG_W-1:0] prod_r;
  kw_cw_t                   rnd_r [4];
  kw_coef_t                 coef_r;
  logic                     busy_r;
  logic [2:0]               step_r;
  logic                     wr_en;
  kw_reg_t                  idx;
  logic signed [REG_W-1:0]  mul_a;
  logic signed [REG_W-1:0]  mul_b;
  logic signed [2*REG_W-1:0] rnd_sum;
  kw_cw_t s0, s1, s2, d1, d2, p1, p2;

  assign idx   = kw_reg_t'(paddr[ADDR_W-1:2]);
  assign wr_en = psel && penable && pwrite && (paddr[ADDR_W-1:2] < 3'(NREGS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r[REG_SHELF_NUM0]    <= RST_SHELF_NUM0;
      regs_r[REG_SHELF_NUM1]    <= RST_SHELF_NUM1;
      regs_r[REG_SHELF_NUM2]    <= RST_SHELF_NUM2;
      regs_r[REG_SHELF_DEN1]    <= RST_SHELF_DEN1;
      regs_r[REG_SHELF_DEN2]    <= RST_SHELF_DEN2;
      regs_r[REG_HIGHPASS_DEN1] <= RST_HIGHPASS_DEN1;
      regs_r[REG_HIGHPASS_DEN2] <= RST_HIGHPASS_DEN2;
    end else if (wr_en) begin
      regs_r[idx] <= pwdata;
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_SHELF_NUM0:    prdata = regs_r[REG_SHELF_NUM0];
      REG_SHELF_NUM1:    prdata = regs_r[REG_SHELF_NUM1];
      REG_SHELF_NUM2:    prdata = regs_r[REG_SHELF_NUM2];
      REG_SHELF_DEN1:    prdata = regs_r[REG_SHELF_DEN1];
      REG_SHELF_DEN2:    prdata = regs_r[REG_SHELF_DEN2];
      REG_HIGHPASS_DEN1: prdata = regs_r[REG_HIGHPASS_DEN1];
      REG_HIGHPASS_DEN2: prdata = regs_r[REG_HIGHPASS_DEN2];
      default:           prdata = '0;
    endcase
  end

  assign s0 = COEF_W'(regs_r[REG_SHELF_NUM0]);
  assign s1 = COEF_W'(regs_r[REG_SHELF_NUM1]);
  assign s2 = COEF_W'(regs_r[REG_SHELF_NUM2]);
  assign d1 = COEF_W'(regs_r[REG_SHELF_DEN1]);
  assign d2 = COEF_W'(regs_r[REG_SHELF_DEN2]);
  assign p1 = COEF_W'(regs_r[REG_HIGHPASS_DEN1]);
  assign p2 = COEF_W'(regs_r[REG_HIGHPASS_DEN2]);

  always_comb begin
    case (step_r[1:0])
      2'd0: begin
        mul_a = regs_r[REG_SHELF_DEN1];
        mul_b = regs_r[REG_HIGHPASS_DEN1];
      end
      2'd1: begin
        mul_a = regs_r[REG_SHELF_DEN1];
        mul_b = regs_r[REG_HIGHPASS_DEN2];
      end
      2'd2: begin
        mul_a = regs_r[REG_SHELF_DEN2];
        mul_b = regs_r[REG_HIGHPASS_DEN1];
      end
      default: begin
        mul_a = regs_r[REG_SHELF_DEN2];
        mul_b = regs_r[REG_HIGHPASS_DEN2];
      end
    endcase
  end

  assign rnd_sum = (prod_r + (64'sd1 <<< 27)) >>> 28;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      step_r <= '0;
    end else if (wr_en) begin
      busy_r <= 1'b1;
      step_r <= '0;
    end else if (busy_r) begin
      if (step_r == 3'd5) begin
        busy_r <= 1'b0;
      end
      step_r <= step_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r && step_r < 3'd4) begin
      prod_r <= mul_a * mul_b;
    end
    if (busy_r && step_r != 3'd0 && step_r < 3'd5) begin
      rnd_r[2'(step_r - 3'd1)] <= rnd_sum[COEF_W-1:0];
    end
    if (busy_r && step_r == 3'd5) begin
      coef_r.b0 <= s0;
      coef_r.b1 <= s1 - (s0 <<< 1);
      coef_r.b2 <= s0 - (s1 <<< 1) + s2;
      coef_r.b3 <= s1 - (s2 <<< 1);
      coef_r.b4 <= s2;
      coef_r.a1 <= d1 + p1;
      coef_r.a2 <= d2 + p2 + rnd_r[0];
      coef_r.a3 <= rnd_r[1] + rnd_r[2];
      coef_r.a4 <= rnd_r[3];
    end
  end

  assign coef = coef_r;
  assign busy = busy_r;

endmodule

[rtl/kw_front.sv]
// ----------------------------------------------------------------------------
// kw_front
// Input acceptance, channel range check and a two-entry queue to the back end.
// ----------------------------------------------------------------------------
module kw_front #(
  parameter int CHANNELS = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  kw_in_if.sink            in_ch,
  input  logic             busy,
  output kw_pkg::kw_item_t q_item,
  output logic             q_valid,
  input  logic             q_pop
);
  import kw_pkg::*;

  kw_item_t   q_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push;
  kw_item_t   item;

  assign in_ch.ready = (cnt_r != 2'd2) && !busy;
  assign push        = in_ch.valid && in_ch.ready;

  always_comb begin
    item.chan     = in_ch.chan_index;
    item.sample   = in_ch.sample_in;
    item.in_range = 32'(in_ch.chan_index) < CHANNELS;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

  assign q_item  = q_r[rd_ptr_r];
  assign q_valid = cnt_r != 2'd0;

endmodule

[rtl/kw_back.sv]
// ----------------------------------------------------------------------------
// kw_back
// Filter engine: history memory, shared multiply-accumulate, rounding,
// saturation and the output register.
// ----------------------------------------------------------------------------
module kw_back #(
  parameter int CHANNELS = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  kw_pkg::kw_item_t q_item,
  input  logic             q_valid,
  output logic             q_pop,
  input  kw_pkg::kw_coef_t coef,
  kw_out_if.source         out_ch
);
  import kw_pkg::*;

  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ROW_W = 4 * HIST_W;

  kw_state_t                 state_r, state_nxt;
  kw_item_t                  item_r;
  logic [3:0]                cnt_r;
  logic signed [HIST_W-1:0]  h_r [4];
  logic signed [HIST_W-1:0]  v_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [PP_W-1:0]    pp_r;
  logic                      pp_v_r;
  logic                      pp_hi_r;
  logic                      pp_neg_r;
  logic signed [OUT_W-1:0]   y_r;
  logic [ROW_W-1:0]          mem [CHANNELS];
  logic [ROW_W-1:0]          rd_row_r;
  logic                      rd_ok_r;
  logic [CHANNELS-1:0]       hval_r;
  logic                      out_valid_r;
  logic [CIDX_W-1:0]         out_chan_r;
  logic signed [OUT_W-1:0]   out_y_r;

  logic                      slot_free;
  logic                      issue;
  logic                      phase_b;
  logic                      finish;
  logic [2:0]                term;
  kw_cw_t                    coef_sel;
  logic signed [HIST_W-1:0]  opnd;
  logic signed [32:0]        opnd_half;
  logic signed [ACC_W-1:0]   pp_ext;
  logic signed [ACC_W-1:0]   pp_sh;
  logic signed [ACC_W-1:0]   rv_sum;
  logic signed [ACC_W-1:0]   ry_sum;
  logic signed [HIST_W-1:0]  v_sat;
  logic signed [OUT_W-1:0]   y_sat;
  logic [CH_W-1:0]           q_idx;
  logic [CH_W-1:0]           w_idx;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign q_idx     = CH_W'(q_item.chan);
  assign w_idx     = CH_W'(item_r.chan);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (q_valid) state_nxt = q_item.in_range ? ST_READ : ST_DONE;
      ST_READ:    state_nxt = ST_MAC_A;
      ST_MAC_A:   if (cnt_r == LAST_A) state_nxt = ST_DRAIN_A;
      ST_DRAIN_A: state_nxt = ST_RND_V;
      ST_RND_V:   state_nxt = ST_MAC_B;
      ST_MAC_B:   if (cnt_r == LAST_B) state_nxt = ST_DRAIN_B;
      ST_DRAIN_B: state_nxt = ST_RND_Y;
      ST_RND_Y:   state_nxt = ST_DONE;
      ST_DONE:    if (slot_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop   = 1'b0;
    issue   = 1'b0;
    phase_b = 1'b0;
    finish  = 1'b0;
    unique case (state_r)
      ST_IDLE:  q_pop = q_valid;
      ST_MAC_A: issue = 1'b1;
      ST_MAC_B: begin
        issue   = 1'b1;
        phase_b = 1'b1;
      end
      ST_DONE:  finish = slot_free;
      default:  issue = 1'b0;
    endcase
  end

  assign term = cnt_r[3:1];

  always_comb begin
    coef_sel = coef.a1;
    opnd     = h_r[0];
    if (!phase_b) begin
      case (term[1:0])
        2'd0:    coef_sel = coef.a1;
        2'd1:    coef_sel = coef.a2;
        2'd2:    coef_sel = coef.a3;
        default: coef_sel = coef.a4;
      endcase
      opnd = h_r[term[1:0]];
    end else begin
      case (term)
        3'd0: begin
          coef_sel = coef.b0;
          opnd     = v_r;
        end
        3'd1:    coef_sel = coef.b1;
        3'd2:    coef_sel = coef.b2;
        3'd3:    coef_sel = coef.b3;
        default: coef_sel = coef.b4;
      endcase
      if (term != 3'd0) begin
        opnd = h_r[2'(term - 3'd1)];
      end
    end
    opnd_half = cnt_r[0] ? {opnd[HIST_W-1], opnd[HIST_W-1:32]} : {1'b0, opnd[31:0]};
  end

  assign pp_ext = {{(ACC_W-PP_W){pp_r[PP_W-1]}}, pp_r};
  assign pp_sh  = pp_hi_r ? (pp_ext <<< 32) : pp_ext;

  assign rv_sum = (acc_r + (104'sd1 <<< 27)) >>> 28;
  assign ry_sum = (acc_r + (104'sd1 <<< 47)) >>> 48;

  always_comb begin
    if (rv_sum[ACC_W-1:HIST_W-1] == '0 || rv_sum[ACC_W-1:HIST_W-1] == '1) begin
      v_sat = rv_sum[HIST_W-1:0];
    end else begin
      v_sat = rv_sum[ACC_W-1] ? {1'b1, {(HIST_W-1){1'b0}}} : {1'b0, {(HIST_W-1){1'b1}}};
    end
    if (ry_sum[ACC_W-1:OUT_W-1] == '0 || ry_sum[ACC_W-1:OUT_W-1] == '1) begin
      y_sat = ry_sum[OUT_W-1:0];
    end else begin
      y_sat = ry_sum[ACC_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pp_v_r      <= 1'b0;
      hval_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pp_v_r  <= issue;
      if (finish) begin
        out_valid_r <= 1'b1;
        if (item_r.in_range) begin
          hval_r[w_idx] <= 1'b1;
        end
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r <= q_item;
      y_r    <= '0;
      if (q_item.in_range) begin
        rd_row_r <= mem[q_idx];
        rd_ok_r  <= hval_r[q_idx];
      end
    end
    if (state_r == ST_READ) begin
      for (int k = 0; k < 4; k++) begin
        h_r[k] <= rd_ok_r ? rd_row_r[k*HIST_W +: HIST_W] : '0;
      end
      acc_r <= {{(ACC_W-SAMP_W-52){item_r.sample[SAMP_W-1]}}, item_r.sample, 52'b0};
    end else if (state_r == ST_RND_V) begin
      acc_r <= '0;
      v_r   <= v_sat;
    end else if (pp_v_r) begin
      acc_r <= pp_neg_r ? acc_r - pp_sh : acc_r + pp_sh;
    end
    if (issue) begin
      pp_r     <= coef_sel * opnd_half;
      pp_hi_r  <= cnt_r[0];
      pp_neg_r <= !phase_b;
    end
    if (state_r == ST_RND_Y) begin
      y_r <= y_sat;
    end
    if (finish) begin
      out_chan_r <= item_r.chan;
      out_y_r    <= y_r;
      if (item_r.in_range) begin
        mem[w_idx] <= {h_r[2], h_r[1], h_r[0], v_r};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (issue && !(cnt_r == LAST_B || (!phase_b && cnt_r == LAST_A))) begin
      cnt_r <= cnt_r + 4'd1;
    end else begin
      cnt_r <= '0;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.chan_out     = out_chan_r;
  assign out_ch.weighted_out = out_y_r;

endmodule

[rtl/k_weighting_iir_filter.sv]
// ----------------------------------------------------------------------------
// k_weighting_iir_filter
// Multichannel fourth-order K-weighting IIR with one filter multiply unit shared by all channels.
// ----------------------------------------------------------------------------
// One item is filtered at a time; each in-range item takes eighteen 37x33
// partial products through the single multiplier of the filter engine.
// Reset: synchronous, active low; history reads as zero and coefficients are
// recombined after reset and after each register write, during which no
// input is taken.
module k_weighting_iir_filter #(
  parameter int CHANNELS = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  kw_in_if.sink                     in_ch,
  kw_out_if.source                  out_ch,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [kw_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [kw_pkg::REG_W-1:0]  cfg_pwdata,
  output logic [kw_pkg::REG_W-1:0]  cfg_prdata,
  output logic                      cfg_pready
);
  import kw_pkg::*;

  kw_coef_t coef;
  logic     busy;
  kw_item_t q_item;
  logic     q_valid;
  logic     q_pop;

  assign cfg_pready = 1'b1;

  kw_coef u_coef (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .coef    (coef),
    .busy    (busy)
  );

  kw_front #(.CHANNELS(CHANNELS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .busy    (busy),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  kw_back #(.CHANNELS(CHANNELS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .coef    (coef),
    .out_ch  (out_ch)
  );

endmodule
